>>> design/rcq_pkg.sv
// Shared types and constants for the RC override qualifier and mirror.
`default_nettype none
package rcq_pkg;

	localparam int PULSE_W = 16;
	localparam int COUNT_W = 4;
	localparam int CFG_IDX_W = 3;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_OVERRIDE_THRESHOLD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_VALID_PULSE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SERVO_MIN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SERVO_MAX = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_COUNT = 3'd4;

	localparam logic [PULSE_W-1:0] RST_OVERRIDE_THRESHOLD = 16'd1700;
	localparam logic [PULSE_W-1:0] RST_MIN_VALID_PULSE = 16'd100;
	localparam logic [PULSE_W-1:0] RST_SERVO_MIN = 16'd1000;
	localparam logic [PULSE_W-1:0] RST_SERVO_MAX = 16'd2000;
	localparam logic [COUNT_W-1:0] RST_CONFIRM_COUNT = 4'd3;

	// reported qualifier state codes
	localparam logic [1:0] QS_MIRRORING = 2'd0;
	localparam logic [1:0] QS_CONFIRM_OVERRIDE = 2'd1;
	localparam logic [1:0] QS_OVERRIDE_ACTIVE = 2'd2;
	localparam logic [1:0] QS_CONFIRM_MIRROR = 2'd3;

	typedef struct packed {
		logic [PULSE_W-1:0] override_threshold_us;
		logic [PULSE_W-1:0] min_valid_pulse_us;
		logic [PULSE_W-1:0] servo_min_us;
		logic [PULSE_W-1:0] servo_max_us;
		logic [COUNT_W-1:0] confirm_count;
	} rcq_cfg_t;

	typedef struct packed {
		logic active;
		logic [1:0] state_code;
	} rcq_status_t;

endpackage
`default_nettype wire

>>> design/rcq_if.sv
// Handshake channels for sample words and result words.
`default_nettype none
interface rcq_sample_if
	import rcq_pkg::*;
;
	logic valid;
	logic ready;
	logic [PULSE_W-1:0] override_pulse_us;
	logic [PULSE_W-1:0] command_pulse_us;

	modport source(output valid, output override_pulse_us, output command_pulse_us,
		input ready);
	modport sink(input valid, input override_pulse_us, input command_pulse_us,
		output ready);
endinterface

interface rcq_result_if
	import rcq_pkg::*;
;
	logic valid;
	logic ready;
	logic override_active;
	logic [1:0] qualifier_state;
	logic mirror_valid;
	logic [PULSE_W-1:0] mirror_pulse_us;

	modport source(output valid, output override_active, output qualifier_state,
		output mirror_valid, output mirror_pulse_us, input ready);
	modport sink(input valid, input override_active, input qualifier_state,
		input mirror_valid, input mirror_pulse_us, output ready);
endinterface
`default_nettype wire

>>> design/rcq_cfg_regs.sv
// Configuration register file with plain write port.
`default_nettype none
module rcq_cfg_regs
	import rcq_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [PULSE_W-1:0]   cfg_data,
	output rcq_cfg_t                  cfg
);

	rcq_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.override_threshold_us <= RST_OVERRIDE_THRESHOLD;
			cfg_q.min_valid_pulse_us <= RST_MIN_VALID_PULSE;
			cfg_q.servo_min_us <= RST_SERVO_MIN;
			cfg_q.servo_max_us <= RST_SERVO_MAX;
			cfg_q.confirm_count <= RST_CONFIRM_COUNT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_OVERRIDE_THRESHOLD: cfg_q.override_threshold_us <= cfg_data;
				CFG_MIN_VALID_PULSE: cfg_q.min_valid_pulse_us <= cfg_data;
				CFG_SERVO_MIN: cfg_q.servo_min_us <= cfg_data;
				CFG_SERVO_MAX: cfg_q.servo_max_us <= cfg_data;
				CFG_CONFIRM_COUNT: cfg_q.confirm_count <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

>>> design/rcq_qualifier.sv
// Debounce state machine for the override channel.
`default_nettype none
module rcq_qualifier
	import rcq_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               step,
	input  wire logic [PULSE_W-1:0] override_pulse_us,
	input  wire rcq_cfg_t           cfg,
	output rcq_status_t             status_next
);

	typedef enum logic [3:0] {
		ST_MIRRORING        = 4'b0001,
		ST_CONFIRM_OVERRIDE = 4'b0010,
		ST_OVERRIDE_ACTIVE  = 4'b0100,
		ST_CONFIRM_MIRROR   = 4'b1000
	} qual_state_t;

	qual_state_t state_q, state_d;
	logic [COUNT_W-1:0] true_cnt_q, true_cnt_d, true_inc;
	logic [COUNT_W-1:0] false_cnt_q, false_cnt_d, false_inc;
	logic active_q, active_d;
	logic [COUNT_W-1:0] need;
	logic meas;

	// count of zero acts as one
	assign need = (cfg.confirm_count == '0) ? COUNT_W'(1) : cfg.confirm_count;
	assign meas = (override_pulse_us > cfg.min_valid_pulse_us) &&
		(override_pulse_us >= cfg.override_threshold_us);
	assign true_inc = (&true_cnt_q) ? true_cnt_q : true_cnt_q + COUNT_W'(1);
	assign false_inc = (&false_cnt_q) ? false_cnt_q : false_cnt_q + COUNT_W'(1);

	always_comb begin
		state_d = state_q;
		true_cnt_d = true_cnt_q;
		false_cnt_d = false_cnt_q;
		active_d = active_q;
		unique case (state_q)
			ST_MIRRORING: begin
				if (meas) begin
					if (need == COUNT_W'(1)) begin
						state_d = ST_OVERRIDE_ACTIVE;
						active_d = 1'b1;
						true_cnt_d = '0;
						false_cnt_d = '0;
					end else begin
						state_d = ST_CONFIRM_OVERRIDE;
						true_cnt_d = COUNT_W'(1);
					end
				end else begin
					true_cnt_d = '0;
					false_cnt_d = '0;
					active_d = 1'b0;
				end
			end
			ST_CONFIRM_OVERRIDE: begin
				if (meas) begin
					true_cnt_d = true_inc;
					if (true_inc >= need) begin
						state_d = ST_OVERRIDE_ACTIVE;
						active_d = 1'b1;
						true_cnt_d = '0;
						false_cnt_d = '0;
					end
				end else begin
					state_d = ST_MIRRORING;
					true_cnt_d = '0;
					false_cnt_d = '0;
					active_d = 1'b0;
				end
			end
			ST_OVERRIDE_ACTIVE: begin
				if (meas) begin
					false_cnt_d = '0;
				end else if (need == COUNT_W'(1)) begin
					state_d = ST_MIRRORING;
					active_d = 1'b0;
					true_cnt_d = '0;
					false_cnt_d = '0;
				end else begin
					state_d = ST_CONFIRM_MIRROR;
					false_cnt_d = COUNT_W'(1);
				end
			end
			ST_CONFIRM_MIRROR: begin
				if (!meas) begin
					false_cnt_d = false_inc;
					if (false_inc >= need) begin
						state_d = ST_MIRRORING;
						active_d = 1'b0;
						true_cnt_d = '0;
						false_cnt_d = '0;
					end
				end else begin
					state_d = ST_OVERRIDE_ACTIVE;
					active_d = 1'b1;
					false_cnt_d = '0;
				end
			end
			default: begin
				state_d = ST_MIRRORING;
				true_cnt_d = '0;
				false_cnt_d = '0;
				active_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_MIRRORING;
			true_cnt_q <= '0;
			false_cnt_q <= '0;
			active_q <= 1'b0;
		end else if (step) begin
			state_q <= state_d;
			true_cnt_q <= true_cnt_d;
			false_cnt_q <= false_cnt_d;
			active_q <= active_d;
		end
	end

	always_comb begin
		status_next.active = active_d;
		unique case (state_d)
			ST_MIRRORING: status_next.state_code = QS_MIRRORING;
			ST_CONFIRM_OVERRIDE: status_next.state_code = QS_CONFIRM_OVERRIDE;
			ST_OVERRIDE_ACTIVE: status_next.state_code = QS_OVERRIDE_ACTIVE;
			ST_CONFIRM_MIRROR: status_next.state_code = QS_CONFIRM_MIRROR;
			default: status_next.state_code = QS_MIRRORING;
		endcase
	end

endmodule
`default_nettype wire

>>> design/rcq_clamp.sv
// Command pulse qualification and servo range clamp.
`default_nettype none
module rcq_clamp
	import rcq_pkg::*;
(
	input  wire logic               active,
	input  wire logic [PULSE_W-1:0] command_pulse_us,
	input  wire rcq_cfg_t           cfg,
	output logic                    mirror_valid,
	output logic [PULSE_W-1:0]      mirror_pulse_us
);

	logic [PULSE_W-1:0] clamped;

	// min is checked first; inverted: below min gives min, else max
	always_comb begin
		if (command_pulse_us < cfg.servo_min_us) begin
			clamped = cfg.servo_min_us;
		end else if (command_pulse_us > cfg.servo_max_us) begin
			clamped = cfg.servo_max_us;
		end else begin
			clamped = command_pulse_us;
		end
	end

	assign mirror_valid = !active && (command_pulse_us > cfg.min_valid_pulse_us) &&
		(clamped != '0);
	assign mirror_pulse_us = mirror_valid ? clamped : '0;

endmodule
`default_nettype wire

>>> design/rc_override_qualifier_mirror.sv
// Top level: RC override qualifier with mirrored servo pulse output.
// Takes one sample word per cycle while not stalled and returns exactly one result
// word per sample. A sample is held in an input register; the qualifier state
// machine, its run counters and the servo clamp are evaluated while it sits there
// and written to the result register when the result register can take it.
// The state machine advances as the sample moves into the result register, so
// back-to-back samples see each other's updates. A stalled result holds both
// registers; ready drops only when both are full. Configuration writes take
// effect on the next cycle and should be made while no sample is in flight.
`default_nettype none
module rc_override_qualifier_mirror
	import rcq_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	rcq_sample_if.sink                sample,
	rcq_result_if.source              result,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [PULSE_W-1:0]   cfg_data
);

	rcq_cfg_t cfg;
	rcq_status_t status_next;

	logic valid_s1;
	logic [PULSE_W-1:0] override_pulse_s1;
	logic [PULSE_W-1:0] command_pulse_s1;

	logic valid_s2;
	logic active_s2;
	logic [1:0] state_s2;
	logic mirror_valid_s2;
	logic [PULSE_W-1:0] mirror_pulse_s2;

	logic advance;
	logic step;
	logic mirror_valid_c;
	logic [PULSE_W-1:0] mirror_pulse_c;

	assign advance = !valid_s2 || result.ready;
	assign step = valid_s1 && advance;
	assign sample.ready = !valid_s1 || advance;

	rcq_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	rcq_qualifier u_qual (
		.clk               (clk),
		.arst_n            (arst_n),
		.step              (step),
		.override_pulse_us (override_pulse_s1),
		.cfg               (cfg),
		.status_next       (status_next)
	);

	rcq_clamp u_clamp (
		.active           (status_next.active),
		.command_pulse_us (command_pulse_s1),
		.cfg              (cfg),
		.mirror_valid     (mirror_valid_c),
		.mirror_pulse_us  (mirror_pulse_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.ready && sample.valid) begin
			override_pulse_s1 <= sample.override_pulse_us;
			command_pulse_s1 <= sample.command_pulse_us;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			active_s2 <= status_next.active;
			state_s2 <= status_next.state_code;
			mirror_valid_s2 <= mirror_valid_c;
			mirror_pulse_s2 <= mirror_pulse_c;
		end
	end

	assign result.valid = valid_s2;
	assign result.override_active = active_s2;
	assign result.qualifier_state = state_s2;
	assign result.mirror_valid = mirror_valid_s2;
	assign result.mirror_pulse_us = mirror_pulse_s2;

`ifndef SYNTHESIS
	// active flag tracks the override half of the state machine
	a_active_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (active_s2 == state_s2[1]))
		else $error("override_active disagrees with qualifier_state");

	a_no_mirror_in_override: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && active_s2) |-> !mirror_valid_s2)
		else $error("mirror word given while override active");

	a_mirror_zero_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !mirror_valid_s2) |-> (mirror_pulse_s2 == '0))
		else $error("mirror pulse nonzero without mirror_valid");

	// a word in the input register is never dropped by a stall
	a_s1_held_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> valid_s1)
		else $error("input word lost during stall");
`endif

endmodule
`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the RC override qualifier and mirror: directed table, then random phases.
module tb;
	import rcq_pkg::*;

	typedef struct packed {
		logic                active;
		logic [1:0]          qstate;
		logic                mvalid;
		logic [PULSE_W-1:0]  mpulse;
	} result_word_t;

	typedef struct {
		bit                   is_write;
		logic [CFG_IDX_W-1:0] idx;
		logic [PULSE_W-1:0]   a;
		logic [PULSE_W-1:0]   b;
		bit                   pinned;
		result_word_t         word;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [PULSE_W-1:0] cfg_data;

	rcq_sample_if sample_ch ();
	rcq_result_if result_ch ();

	// typed-in expectation travels with the word it belongs to
	logic pin_en;
	result_word_t pin_word;

	// predictor copy of the block
	logic [1:0] qual_mode;
	logic [COUNT_W-1:0] true_run;
	logic [COUNT_W-1:0] false_run;
	logic active_flag;
	logic [PULSE_W-1:0] cfg_thr;
	logic [PULSE_W-1:0] cfg_minv;
	logic [PULSE_W-1:0] cfg_smin;
	logic [PULSE_W-1:0] cfg_smax;
	logic [COUNT_W-1:0] cfg_confirm;

	result_word_t pending_results[$];
	stim_row_t stim_rows[$];
	int err_count = 0;
	bit idle_on = 1'b1;
	bit long_hold_req = 1'b0;

	rc_override_qualifier_mirror u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample(sample_ch),
		.result(result_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic logic [COUNT_W-1:0] run_inc(input logic [COUNT_W-1:0] v);
		return (v == 4'd15) ? v : v + 4'd1;
	endfunction

	// advances the qualifier copy by one sample and returns the result word
	function automatic result_word_t qualify_sample(input logic [PULSE_W-1:0] ovr,
		input logic [PULSE_W-1:0] cmd);
		logic [COUNT_W-1:0] need;
		logic meas;
		logic [PULSE_W-1:0] pulse;
		result_word_t w;
		need = (cfg_confirm == 4'd0) ? 4'd1 : cfg_confirm;
		meas = (ovr > cfg_minv) && (ovr >= cfg_thr);
		case (qual_mode)
			QS_MIRRORING: begin
				if (meas) begin
					if (need == 4'd1) begin
						qual_mode = QS_OVERRIDE_ACTIVE;
						active_flag = 1'b1;
						true_run = 4'd0;
						false_run = 4'd0;
					end else begin
						qual_mode = QS_CONFIRM_OVERRIDE;
						true_run = 4'd1;
					end
				end else begin
					true_run = 4'd0;
					false_run = 4'd0;
					active_flag = 1'b0;
				end
			end
			QS_CONFIRM_OVERRIDE: begin
				if (meas) begin
					true_run = run_inc(true_run);
					if (true_run >= need) begin
						qual_mode = QS_OVERRIDE_ACTIVE;
						active_flag = 1'b1;
						true_run = 4'd0;
						false_run = 4'd0;
					end
				end else begin
					qual_mode = QS_MIRRORING;
					true_run = 4'd0;
					false_run = 4'd0;
					active_flag = 1'b0;
				end
			end
			QS_OVERRIDE_ACTIVE: begin
				if (meas) begin
					false_run = 4'd0;
				end else if (need == 4'd1) begin
					qual_mode = QS_MIRRORING;
					active_flag = 1'b0;
					true_run = 4'd0;
					false_run = 4'd0;
				end else begin
					qual_mode = QS_CONFIRM_MIRROR;
					false_run = 4'd1;
				end
			end
			default: begin
				if (!meas) begin
					false_run = run_inc(false_run);
					if (false_run >= need) begin
						qual_mode = QS_MIRRORING;
						active_flag = 1'b0;
						true_run = 4'd0;
						false_run = 4'd0;
					end
				end else begin
					qual_mode = QS_OVERRIDE_ACTIVE;
					active_flag = 1'b1;
					false_run = 4'd0;
				end
			end
		endcase
		w = '0;
		w.active = active_flag;
		w.qstate = qual_mode;
		if (!active_flag && cmd > cfg_minv) begin
			if (cmd < cfg_smin)
				pulse = cfg_smin;
			else if (cmd > cfg_smax)
				pulse = cfg_smax;
			else
				pulse = cmd;
			if (pulse != '0) begin
				w.mvalid = 1'b1;
				w.mpulse = pulse;
			end
		end
		return w;
	endfunction

	function automatic void add_sample(input logic [PULSE_W-1:0] ovr,
		input logic [PULSE_W-1:0] cmd);
		stim_row_t r;
		r = '{default: '0};
		r.a = ovr;
		r.b = cmd;
		stim_rows.push_back(r);
	endfunction

	function automatic void add_pinned(input logic [PULSE_W-1:0] ovr,
		input logic [PULSE_W-1:0] cmd, input result_word_t w);
		stim_row_t r;
		r = '{default: '0};
		r.a = ovr;
		r.b = cmd;
		r.pinned = 1'b1;
		r.word = w;
		stim_rows.push_back(r);
	endfunction

	function automatic void add_write(input logic [CFG_IDX_W-1:0] idx,
		input logic [PULSE_W-1:0] val);
		stim_row_t r;
		r = '{default: '0};
		r.is_write = 1'b1;
		r.idx = idx;
		r.a = val;
		stim_rows.push_back(r);
	endfunction

	// entered at a rising edge; returns at the edge where the word is taken
	task automatic send_word(input logic [PULSE_W-1:0] ovr, input logic [PULSE_W-1:0] cmd,
		input bit pinned, input result_word_t w);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			sample_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.override_pulse_us <= ovr;
		sample_ch.command_pulse_us <= cmd;
		pin_en <= pinned;
		pin_word <= w;
		@(posedge clk);
		while (!sample_ch.ready) @(posedge clk);
	endtask

	task automatic wait_idle();
		sample_ch.valid <= 1'b0;
		// let the sampling edge pass so the last accepted word is already queued
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PULSE_W-1:0] val);
		wait_idle();
		case (idx)
			CFG_OVERRIDE_THRESHOLD: cfg_thr = val;
			CFG_MIN_VALID_PULSE: cfg_minv = val;
			CFG_SERVO_MIN: cfg_smin = val;
			CFG_SERVO_MAX: cfg_smax = val;
			CFG_CONFIRM_COUNT: cfg_confirm = val[COUNT_W-1:0];
			default: ;
		endcase
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	always @(posedge clk) begin : sample_mon
		result_word_t predicted;
		if (arst_n && sample_ch.valid && sample_ch.ready) begin
			predicted = qualify_sample(sample_ch.override_pulse_us, sample_ch.command_pulse_us);
			if (pin_en)
				pending_results.push_back(pin_word);
			else
				pending_results.push_back(predicted);
		end
	end

	always @(posedge clk) begin : result_mon
		result_word_t exp_w;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_results.size() == 0) begin
				$error("result word with no expectation waiting");
				err_count++;
			end else begin
				exp_w = pending_results.pop_front();
				if (result_ch.override_active !== exp_w.active) begin
					$error("override_active: expected %0d, actual %0d",
						exp_w.active, result_ch.override_active);
					err_count++;
				end
				if (result_ch.qualifier_state !== exp_w.qstate) begin
					$error("qualifier_state: expected %0d, actual %0d",
						exp_w.qstate, result_ch.qualifier_state);
					err_count++;
				end
				if (result_ch.mirror_valid !== exp_w.mvalid) begin
					$error("mirror_valid: expected %0d, actual %0d",
						exp_w.mvalid, result_ch.mirror_valid);
					err_count++;
				end
				if (result_ch.mirror_pulse_us !== exp_w.mpulse) begin
					$error("mirror_pulse_us: expected %0d, actual %0d",
						exp_w.mpulse, result_ch.mirror_pulse_us);
					err_count++;
				end
			end
		end
	end

	// result side: random stall bursts while idle_on, plus one long hold on request
	initial begin : receiver
		int hold_left;
		int gap_left;
		hold_left = 0;
		gap_left = 0;
		result_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left = 80;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else if (!idle_on) begin
				gap_left = 0;
				result_ch.ready <= 1'b1;
			end else if (gap_left > 0) begin
				gap_left--;
				result_ch.ready <= 1'b0;
			end else if ($urandom_range(0, 5) == 0) begin
				gap_left = $urandom_range(0, 11);
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	initial begin : limit
		#5000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin : sender
		int p;
		int n;
		int r;
		int run_left;
		bit run_truth;
		bit noise;
		int lo_true;
		int hi_false;
		logic [PULSE_W-1:0] ovr;
		logic [PULSE_W-1:0] cmd;
		logic [PULSE_W-1:0] a;
		logic [PULSE_W-1:0] b;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		sample_ch.valid = 1'b0;
		sample_ch.override_pulse_us = '0;
		sample_ch.command_pulse_us = '0;
		pin_en = 1'b0;
		pin_word = '0;
		qual_mode = QS_MIRRORING;
		true_run = '0;
		false_run = '0;
		active_flag = 1'b0;
		cfg_thr = RST_OVERRIDE_THRESHOLD;
		cfg_minv = RST_MIN_VALID_PULSE;
		cfg_smin = RST_SERVO_MIN;
		cfg_smax = RST_SERVO_MAX;
		cfg_confirm = RST_CONFIRM_COUNT;

		// reset values, clamp edges, validity edge
		add_pinned(16'd0, 16'd0, {1'b0, QS_MIRRORING, 1'b0, 16'd0});
		add_pinned(16'd0, 16'd65535, {1'b0, QS_MIRRORING, 1'b1, 16'd2000});
		add_pinned(16'd0, 16'd101, {1'b0, QS_MIRRORING, 1'b1, 16'd1000});
		add_pinned(16'd0, 16'd100, {1'b0, QS_MIRRORING, 1'b0, 16'd0});
		add_pinned(16'd1700, 16'd1500, {1'b0, QS_CONFIRM_OVERRIDE, 1'b1, 16'd1500});
		add_pinned(16'd1699, 16'd1500, {1'b0, QS_MIRRORING, 1'b1, 16'd1500});
		repeat (3) add_sample(16'd65535, 16'd1500);
		add_sample(16'd0, 16'd1500);
		add_sample(16'd2000, 16'd1500);
		repeat (3) add_sample(16'd0, 16'd1200);
		// single-sample switching
		add_write(CFG_CONFIRM_COUNT, 16'd1);
		add_pinned(16'd1700, 16'd1500, {1'b1, QS_OVERRIDE_ACTIVE, 1'b0, 16'd0});
		add_pinned(16'd0, 16'd1500, {1'b0, QS_MIRRORING, 1'b1, 16'd1500});
		add_write(CFG_CONFIRM_COUNT, 16'd0);
		add_sample(16'd1800, 16'd1500);
		add_sample(16'd0, 16'd0);
		// count lowered under a running confirmation
		add_write(CFG_CONFIRM_COUNT, 16'd15);
		repeat (4) add_sample(16'd2000, 16'd1500);
		add_write(CFG_CONFIRM_COUNT, 16'd2);
		add_sample(16'd2000, 16'd1500);
		// servo min above max
		add_write(CFG_SERVO_MIN, 16'd3000);
		add_write(CFG_SERVO_MAX, 16'd1000);
		add_sample(16'd0, 16'd2000);
		add_sample(16'd0, 16'd5000);
		add_sample(16'd0, 16'd2000);
		// clamp to zero gives no mirror value
		add_write(CFG_SERVO_MIN, 16'd0);
		add_write(CFG_SERVO_MAX, 16'd0);
		add_sample(16'd0, 16'd500);
		add_write(CFG_OVERRIDE_THRESHOLD, 16'd0);
		add_write(CFG_MIN_VALID_PULSE, 16'd0);
		add_write(CFG_SERVO_MAX, 16'd65535);
		add_sample(16'd1, 16'd65535);
		add_sample(16'd1, 16'd1);
		add_write(CFG_MIN_VALID_PULSE, 16'd65535);
		add_write(CFG_OVERRIDE_THRESHOLD, 16'd65535);
		add_sample(16'd65535, 16'd65535);
		add_sample(16'd65535, 16'd65535);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_rows[i]) begin
			if (stim_rows[i].is_write)
				write_reg(stim_rows[i].idx, stim_rows[i].a);
			else
				send_word(stim_rows[i].a, stim_rows[i].b, stim_rows[i].pinned,
					stim_rows[i].word);
		end

		for (p = 0; p < 8; p++) begin
			r = $urandom_range(0, 9);
			a = (r == 0) ? 16'd0 : (r == 1) ? 16'd65535 : 16'($urandom_range(800, 2400));
			write_reg(CFG_OVERRIDE_THRESHOLD, a);
			r = $urandom_range(0, 11);
			a = (r == 0) ? 16'd0 : (r == 1) ? 16'd65535 : 16'($urandom_range(0, 400));
			write_reg(CFG_MIN_VALID_PULSE, a);
			r = $urandom_range(0, 7);
			a = 16'($urandom_range(500, 1500));
			b = 16'($urandom_range(1500, 2500));
			if (r == 0) begin
				a = 16'd0;
				b = 16'd65535;
			end else if (r == 1) begin
				// inverted clamp window
				a = 16'($urandom_range(1500, 2500));
				b = 16'($urandom_range(500, 1500));
			end else if (r == 2) begin
				a = 16'($urandom);
				b = 16'($urandom);
			end
			write_reg(CFG_SERVO_MIN, a);
			write_reg(CFG_SERVO_MAX, b);
			a = 16'($urandom) & 16'hFFF0;
			a[COUNT_W-1:0] = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
				: 4'($urandom_range(1, 4));
			write_reg(CFG_CONFIRM_COUNT, a);

			if (p == 2)
				long_hold_req = 1'b1;
			if (p == 7)
				idle_on = 1'b0;

			lo_true = (int'(cfg_minv) + 1 > int'(cfg_thr)) ? int'(cfg_minv) + 1 : int'(cfg_thr);
			hi_false = (cfg_thr == 0 || int'(cfg_minv) > int'(cfg_thr) - 1) ? int'(cfg_minv)
				: int'(cfg_thr) - 1;
			run_left = 0;
			run_truth = 1'b0;
			noise = 1'b0;
			for (n = 0; n < 100; n++) begin
				if (run_left == 0) begin
					noise = ($urandom_range(0, 3) == 0);
					run_truth = $urandom_range(0, 1);
					run_left = noise ? 1 : $urandom_range(1, int'(cfg_confirm) + 2);
				end
				run_left--;
				if (noise || (run_truth && lo_true > 65535)) begin
					ovr = 16'($urandom);
				end else if (run_truth) begin
					ovr = ($urandom_range(0, 1) == 0) ? 16'(lo_true)
						: 16'($urandom_range(lo_true, 65535));
				end else begin
					r = $urandom_range(0, 5);
					ovr = (r == 0) ? 16'd0 : (r == 1) ? 16'(hi_false)
						: 16'($urandom_range(0, hi_false));
				end
				r = $urandom_range(0, 7);
				cmd = (r == 0) ? 16'd0 : (r < 3) ? 16'($urandom) : 16'($urandom_range(0, 2500));
				send_word(ovr, cmd, 1'b0, '0);
			end
		end

		sample_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d expected result words never arrived", pending_results.size());
			err_count++;
		end
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
